// ===== sv/cif_pkg.sv =====
`timescale 1ns / 1ps

package cif_pkg;

    localparam logic [31:0] ID_LIMIT  = 32'h1FFF_FFFF;
    localparam logic [3:0]  DLC_MAX   = 4'd8;
    localparam int          ID_W      = 29;
    localparam int          BYTE_W    = 8;
    localparam int          SLOT_W    = 9;
    localparam int          VERDICT_W = 3;

    typedef enum logic [VERDICT_W-1:0] {
        VER_IN_RANGE  = 3'd0,
        VER_ANOMALY   = 3'd1,
        VER_UNKNOWN   = 3'd2,
        VER_MALFORMED = 3'd3,
        VER_STORED    = 3'd4,
        VER_REJECTED  = 3'd5
    } t_verdict;

    typedef enum logic [1:0] {
        KIND_STORE,
        KIND_REJECT,
        KIND_MALFORMED,
        KIND_SEARCH
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   ident;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
    } t_rule;

    typedef enum logic {
        BS_IDLE,
        BS_WALK
    } t_back_state;

    typedef struct packed {
        logic walking;
        logic out_full;
    } t_back_status;

endpackage

// ===== sv/cif_ram.sv =====
`timescale 1ns / 1ps

module cif_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/cif_front.sv =====
`timescale 1ns / 1ps

module cif_front #(
    parameter int RULE_SLOTS = 512,
    parameter int CW         = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic [31:0]        i_frame_id,
    input  logic [7:0]         i_first_byte,
    input  logic [3:0]         i_length_code,
    input  logic [7:0]         i_bound_low,
    input  logic [7:0]         i_bound_high,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output cif_pkg::t_cmd      o_cmd,
    output logic [CW-1:0]      o_slot
);

    // Count of rules including stores still in flight toward the table.
    logic [CW-1:0] r_held;
    logic [CW-1:0] n_held;
    logic          id_ok;
    cif_pkg::t_cmd cmd;

    assign id_ok = (i_frame_id <= cif_pkg::ID_LIMIT);

    always_comb begin
        cmd.ident = i_frame_id[cif_pkg::ID_W-1:0];
        cmd.data  = i_first_byte;
        cmd.lo    = i_bound_low;
        cmd.hi    = i_bound_high;
        if (!i_action) begin
            if (id_ok && (i_bound_low <= i_bound_high) && (r_held < CW'(RULE_SLOTS))) begin
                cmd.kind = cif_pkg::KIND_STORE;
            end else begin
                cmd.kind = cif_pkg::KIND_REJECT;
            end
        end else begin
            if (!id_ok || (i_length_code == 4'd0) || (i_length_code > cif_pkg::DLC_MAX)) begin
                cmd.kind = cif_pkg::KIND_MALFORMED;
            end else begin
                cmd.kind = cif_pkg::KIND_SEARCH;
            end
        end
    end

    always_comb begin
        n_held = r_held;
        if (i_valid && i_push_ready && (cmd.kind == cif_pkg::KIND_STORE)) begin
            n_held = r_held + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            r_held <= n_held;
        end
    end

    // A store carries its slot; a search carries the count of rules ahead of it.
    assign o_push_valid = i_valid;
    assign o_ready      = i_push_ready;
    assign o_cmd        = cmd;
    assign o_slot       = r_held;

endmodule

// ===== sv/cif_queue.sv =====
`timescale 1ns / 1ps

module cif_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         push;
    logic         pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/cif_back.sv =====
`timescale 1ns / 1ps

module cif_back #(
    parameter int RULE_SLOTS = 512,
    parameter int CW         = 10,
    parameter int AW         = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_q_ready,
    input  cif_pkg::t_cmd                 i_q_cmd,
    input  logic [CW-1:0]                 i_q_slot,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cif_pkg::VERDICT_W-1:0] o_verdict,
    output logic [cif_pkg::SLOT_W-1:0]    o_rule_slot,
    output cif_pkg::t_back_status         o_status
);

    localparam int SW = cif_pkg::SLOT_W;
    localparam int RW = $bits(cif_pkg::t_rule);

    cif_pkg::t_back_state r_state, n_state;
    cif_pkg::t_cmd        r_cmd, n_cmd;
    logic [CW-1:0]        r_limit, n_limit;
    logic [CW-1:0]        r_rd_idx, n_rd_idx;
    logic [AW-1:0]        r_cmp_idx, n_cmp_idx;
    logic                 r_cmp_valid, n_cmp_valid;
    logic                 r_out_valid, n_out_valid;
    cif_pkg::t_verdict    r_verdict, n_verdict;
    logic [SW-1:0]        r_slot, n_slot;

    logic                 out_free;
    logic                 ram_we;
    logic                 ram_re;
    cif_pkg::t_rule       ram_wdata;
    logic [RW-1:0]        ram_rdata;
    cif_pkg::t_rule       rd_rule;

    cif_ram #(
        .W     (RW),
        .DEPTH (RULE_SLOTS),
        .AW    (AW)
    ) u_rules (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_q_slot[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_rule  = ram_rdata;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        ram_wdata.ident = i_q_cmd.ident;
        ram_wdata.lo    = i_q_cmd.lo;
        ram_wdata.hi    = i_q_cmd.hi;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_limit     = r_limit;
        n_rd_idx    = r_rd_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_valid = r_cmp_valid;
        n_out_valid = r_out_valid;
        n_verdict   = r_verdict;
        n_slot      = r_slot;
        o_q_ready   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            cif_pkg::BS_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_ready = 1'b1;
                    n_cmd     = i_q_cmd;
                    n_limit   = i_q_slot;
                    case (i_q_cmd.kind)
                        cif_pkg::KIND_STORE: begin
                            ram_we      = 1'b1;
                            n_out_valid = 1'b1;
                            n_verdict   = cif_pkg::VER_STORED;
                            n_slot      = SW'(i_q_slot);
                        end
                        cif_pkg::KIND_REJECT: begin
                            n_out_valid = 1'b1;
                            n_verdict   = cif_pkg::VER_REJECTED;
                            n_slot      = '0;
                        end
                        cif_pkg::KIND_MALFORMED: begin
                            n_out_valid = 1'b1;
                            n_verdict   = cif_pkg::VER_MALFORMED;
                            n_slot      = '0;
                        end
                        cif_pkg::KIND_SEARCH: begin
                            if (i_q_slot == '0) begin
                                n_out_valid = 1'b1;
                                n_verdict   = cif_pkg::VER_UNKNOWN;
                                n_slot      = '0;
                            end else begin
                                n_state     = cif_pkg::BS_WALK;
                                n_rd_idx    = '0;
                                n_cmp_valid = 1'b0;
                            end
                        end
                        default: begin
                            n_state = r_state;
                        end
                    endcase
                end
            end
            cif_pkg::BS_WALK: begin
                // One read is issued per cycle while the entry returned by the previous read
                // is compared; the output register is always empty here.
                if (r_cmp_valid && (rd_rule.ident == r_cmd.ident)) begin
                    n_state     = cif_pkg::BS_IDLE;
                    n_cmp_valid = 1'b0;
                    n_out_valid = 1'b1;
                    n_slot      = SW'(r_cmp_idx);
                    if ((r_cmd.data < rd_rule.lo) || (r_cmd.data > rd_rule.hi)) begin
                        n_verdict = cif_pkg::VER_ANOMALY;
                    end else begin
                        n_verdict = cif_pkg::VER_IN_RANGE;
                    end
                end else if (r_rd_idx < r_limit) begin
                    ram_re      = 1'b1;
                    n_cmp_idx   = r_rd_idx[AW-1:0];
                    n_cmp_valid = 1'b1;
                    n_rd_idx    = r_rd_idx + CW'(1);
                end else begin
                    n_state     = cif_pkg::BS_IDLE;
                    n_cmp_valid = 1'b0;
                    n_out_valid = 1'b1;
                    n_verdict   = cif_pkg::VER_UNKNOWN;
                    n_slot      = '0;
                end
            end
            default: begin
                n_state = cif_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cif_pkg::BS_IDLE;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= n_cmp_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_limit   <= n_limit;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_verdict <= n_verdict;
        r_slot    <= n_slot;
    end

    assign o_valid           = r_out_valid;
    assign o_verdict         = r_verdict;
    assign o_rule_slot       = r_slot;
    assign o_status.walking  = (r_state == cif_pkg::BS_WALK);
    assign o_status.out_full = r_out_valid;

endmodule

// ===== sv/can_id_range_whitelist_filter.sv =====
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     i_valid / o_ready    i_action, i_frame_id, i_first_byte, i_length_code,
//                                i_bound_low, i_bound_high
// output    o_valid / i_ready    o_verdict, o_rule_slot
//
// A load, a rejected load or a malformed frame passes from the queue straight into
// the output register, with no walk of the rule memory.
// A frame check walks the rule memory one entry per cycle through its single read
// port, over at most the N rules held, and its result is registered in the output
// register once a rule matches its identifier or all N have been read.
// Reset clears the rule count, the queue and the control state; rule contents are
// undefined until loaded, and no clearing pass is needed.
// A two-entry queue keeps accepting transactions while a walk runs, until full;
// the output register holds a result until it is taken, and the back end waits for it.

module can_id_range_whitelist_filter #(
    parameter int RULE_SLOTS = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [31:0]                   i_frame_id,
    input  logic [7:0]                    i_first_byte,
    input  logic [3:0]                    i_length_code,
    input  logic [7:0]                    i_bound_low,
    input  logic [7:0]                    i_bound_high,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cif_pkg::VERDICT_W-1:0] o_verdict,
    output logic [cif_pkg::SLOT_W-1:0]    o_rule_slot
);

    localparam int CW = $clog2(RULE_SLOTS + 1);
    localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int QW = $bits(cif_pkg::t_cmd) + CW;

    logic                  push_valid;
    logic                  push_ready;
    cif_pkg::t_cmd         cmd;
    logic [CW-1:0]         slot;
    logic                  q_valid;
    logic                  q_ready;
    logic [QW-1:0]         q_data;
    cif_pkg::t_cmd         q_cmd;
    logic [CW-1:0]         q_slot;
    cif_pkg::t_back_status back_status;

    cif_front #(
        .RULE_SLOTS (RULE_SLOTS),
        .CW         (CW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_frame_id    (i_frame_id),
        .i_first_byte  (i_first_byte),
        .i_length_code (i_length_code),
        .i_bound_low   (i_bound_low),
        .i_bound_high  (i_bound_high),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_cmd         (cmd),
        .o_slot        (slot)
    );

    cif_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push_valid),
        .o_ready (push_ready),
        .i_data  ({cmd, slot}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    assign q_cmd  = q_data[QW-1:CW];
    assign q_slot = q_data[CW-1:0];

    cif_back #(
        .RULE_SLOTS (RULE_SLOTS),
        .CW         (CW),
        .AW         (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_cmd     (q_cmd),
        .i_q_slot    (q_slot),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_verdict   (o_verdict),
        .o_rule_slot (o_rule_slot),
        .o_status    (back_status)
    );

    a_store_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_valid && push_ready && (cmd.kind == cif_pkg::KIND_STORE))
            |-> (slot < CW'(RULE_SLOTS)))
        else $error("store transaction points past the rule table");

    a_walk_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_status.walking |-> !back_status.out_full)
        else $error("rule walk running while a result is still held");

    a_zero_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_verdict == cif_pkg::VER_UNKNOWN)
                  || (o_verdict == cif_pkg::VER_MALFORMED)
                  || (o_verdict == cif_pkg::VER_REJECTED)))
            |-> (o_rule_slot == '0))
        else $error("slot index set on a result without a rule");

endmodule
